[sv/cdf_pkg.sv]
// Shared widths and constants for the centroid defuzzifier.
`default_nettype none
package cdf_pkg;

	// Field widths of a breakpoint and of a result
	localparam int X_W = 16;
	localparam int M_W = 16;

	// Membership of 1.0 in Q1.15; larger values are clamped to it
	localparam logic [M_W-1:0] MEMB_ONE = 16'd32768;

	// Default bound on breakpoints per set
	localparam int DEFAULT_MAX_POINTS = 256;

	// Shared multiplier operand width and product width
	localparam int MUL_W  = 18;
	localparam int PROD_W = 2 * MUL_W;

	// Doubled segment area |dx * p| < 2^32, held signed
	localparam int A2_W = 34;
	// Low slice of the doubled area used in the first moment product
	localparam int A2_LO_W = 17;

	// Sum widths before the growth from the number of segments
	localparam int AREA_BASE_W = 34;
	localparam int MOM_BASE_W  = 50;

	// Division by three: floor(n / 3) = (n * RECIP3) >> RECIP3_SH for n < 2^17
	localparam logic [MUL_W-1:0] RECIP3 = 18'd87382;
	localparam int RECIP3_SH = 18;

	// Quotient bits developed by the divider; anything larger saturates
	localparam int QUO_W = 17;
	localparam logic [QUO_W-1:0] POS_LIMIT = 17'd32767;
	localparam logic [QUO_W-1:0] NEG_LIMIT = 17'd32768;

endpackage
`default_nettype wire

[sv/cdf_point_if.sv]
// Valid/ready channel carrying one breakpoint per beat.
`default_nettype none
interface cdf_point_if;
	import cdf_pkg::*;

	logic                  valid;
	logic                  ready;
	logic signed [X_W-1:0] point_x;
	logic [M_W-1:0]        membership;
	logic                  last_point;

	modport source (output valid, output point_x, output membership, output last_point,
		input ready);
	modport sink (input valid, input point_x, input membership, input last_point,
		output ready);

endinterface
`default_nettype wire

[sv/cdf_result_if.sv]
// Valid/ready channel carrying one centroid result per beat.
`default_nettype none
interface cdf_result_if;
	import cdf_pkg::*;

	logic                  valid;
	logic                  ready;
	logic signed [X_W-1:0] crisp_value;
	logic                  empty_area;
	logic                  too_many_points;

	modport source (output valid, output crisp_value, output empty_area,
		output too_many_points, input ready);
	modport sink (input valid, input crisp_value, input empty_area,
		input too_many_points, output ready);

endinterface
`default_nettype wire

[sv/centroid_defuzzifier_core.sv]
// Centroid defuzzifier: one breakpoint per beat in, one centroid per closed set out.
//
// Breakpoints (Q8.8 x, Q1.15 membership) arrive in order; a beat with last_point set
// closes the set and yields one result beat: crisp_value = sum(centre * area) /
// sum(area), truncated toward zero and saturated, or 0 with empty_area when the area
// is zero; too_many_points reports a set longer than MAX_POINTS (extra points are
// dropped). All arithmetic goes through one shared 18x18 signed multiplier and one
// restoring divider under a small sequencer. The input is held not ready while a
// point is worked: a first or dropped point is taken in the accept state alone, any
// later point passes through accept, centre by reciprocal of three, doubled area and
// two moment partial products. A closing point then takes magnitudes, checks the
// range, runs 17 divider steps (one quotient bit per cycle) and loads the output
// register; a zero area skips the range check and the divider, and an out-of-range
// quotient skips the divider. The load waits while an earlier result is still held.
// The output register lets the next set start while a result still waits to be taken.
`default_nettype none
module centroid_defuzzifier_core #(
	parameter int MAX_POINTS = cdf_pkg::DEFAULT_MAX_POINTS
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	cdf_point_if.sink     points,
	cdf_result_if.source  crisp
);
	import cdf_pkg::*;

	localparam int LOG_P  = $clog2(MAX_POINTS);
	localparam int AREA_W = AREA_BASE_W + LOG_P;
	localparam int MOM_W  = MOM_BASE_W + LOG_P;
	localparam int DIV_W  = AREA_W + QUO_W + 1;
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int STEP_W = $clog2(QUO_W);
	localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_POINTS);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUO_W - 1);

	// Sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_THIRD = 4'd1;
	localparam logic [3:0] S_AREA  = 4'd2;
	localparam logic [3:0] S_MLO   = 4'd3;
	localparam logic [3:0] S_MHI   = 4'd4;
	localparam logic [3:0] S_PREP  = 4'd5;
	localparam logic [3:0] S_DSAT  = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_EMIT  = 4'd8;

	logic [3:0]              state_q;

	// Current point and set state
	logic signed [X_W-1:0]   cur_x_q;
	logic [M_W-1:0]          cur_m_q;
	logic                    last_q;
	logic signed [X_W-1:0]   prev_x_q;
	logic [M_W-1:0]          prev_m_q;
	logic [CNT_W-1:0]        count_q;
	logic                    overflow_q;
	logic signed [AREA_W-1:0] area_q;
	logic signed [MOM_W-1:0]  mom_q;

	// Segment working registers
	logic signed [X_W-1:0]   mid_q;
	logic signed [A2_W-1:0]  a2_q;

	// Divider registers
	logic [DIV_W-1:0]        rem_q;
	logic [DIV_W-1:0]        dsh_q;
	logic [QUO_W-1:0]        quo_q;
	logic [STEP_W-1:0]       step_q;
	logic                    neg_q;
	logic                    empty_q;

	// Output register
	logic                    out_valid_q;
	logic signed [X_W-1:0]   out_x_q;
	logic                    out_empty_q;
	logic                    out_over_q;

	logic                    in_fire;
	logic [M_W-1:0]          m_clamped;

	logic signed [X_W:0]     dx;
	logic [X_W:0]            dx_abs;
	logic                    seg_single;
	logic                    seg_tri;
	logic                    seg_rect;
	logic [M_W:0]            area_factor;
	logic [MUL_W-1:0]        third_arg;
	logic [QUO_W-1:0]        q3;
	logic signed [X_W:0]     mid_off;
	logic signed [X_W:0]     mid_full;

	logic signed [MUL_W-1:0] mul_a;
	logic signed [MUL_W-1:0] mul_b;
	logic signed [PROD_W-1:0] prod;

	logic [MOM_W-1:0]        mom_abs;
	logic [AREA_W-1:0]       area_abs;
	logic                    rem_ge;
	logic                    out_slot_free;
	logic signed [X_W-1:0]   crisp_next;

	assign in_fire       = points.valid && points.ready;
	assign points.ready  = (state_q == S_IDLE);
	assign m_clamped     = (points.membership > MEMB_ONE) ? MEMB_ONE : points.membership;
	assign out_slot_free = !out_valid_q || crisp.ready;

	// Classify the segment from the previous point to the current one
	always_comb begin
		dx         = (X_W+1)'(cur_x_q) - (X_W+1)'(prev_x_q);
		dx_abs     = dx[X_W] ? (X_W+1)'(-dx) : (X_W+1)'(dx);
		seg_single = (dx == '0);
		seg_tri    = (prev_m_q == '0) || (cur_m_q == '0);
		seg_rect   = (prev_m_q == cur_m_q);
		if (seg_tri) begin
			area_factor = (M_W+1)'((prev_m_q != '0) ? prev_m_q : cur_m_q);
		end else if (seg_rect) begin
			area_factor = {prev_m_q, 1'b0};
		end else begin
			area_factor = (M_W+1)'(prev_m_q) + (M_W+1)'(cur_m_q);
		end
		// Two thirds of the span when the segment rises, else one third
		third_arg = (prev_m_q < cur_m_q) ? {dx_abs, 1'b0} : MUL_W'(dx_abs);
	end

	// Shared multiplier with operands chosen by the sequencer
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_THIRD: begin
				mul_a = signed'(third_arg);
				mul_b = signed'(RECIP3);
			end
			S_AREA: begin
				if (seg_single) begin
					mul_a = MUL_W'(2);
					mul_b = signed'(MUL_W'(prev_m_q));
				end else begin
					mul_a = MUL_W'(dx);
					mul_b = signed'(MUL_W'(area_factor));
				end
			end
			S_MLO: begin
				mul_a = MUL_W'(mid_q);
				mul_b = signed'(MUL_W'(a2_q[A2_LO_W-1:0]));
			end
			S_MHI: begin
				mul_a = MUL_W'(mid_q);
				mul_b = MUL_W'($signed(a2_q[A2_W-1:A2_LO_W]));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign prod = mul_a * mul_b;

	// Segment centre: x, x + one or two thirds of span, or x + half span, all toward zero
	always_comb begin
		q3 = prod[RECIP3_SH +: QUO_W];
		if (seg_single) begin
			mid_off = '0;
		end else if (seg_tri) begin
			mid_off = dx[X_W] ? (X_W+1)'(-signed'(q3)) : signed'(q3);
		end else begin
			mid_off = (dx + signed'((X_W+1)'(dx[X_W]))) >>> 1;
		end
		mid_full = (X_W+1)'(prev_x_q) + mid_off;
	end

	// Magnitudes for the final division
	always_comb begin
		mom_abs  = mom_q[MOM_W-1] ? MOM_W'(-mom_q) : MOM_W'(mom_q);
		area_abs = area_q[AREA_W-1] ? AREA_W'(-area_q) : AREA_W'(area_q);
		rem_ge   = (rem_q >= dsh_q);
	end

	// Saturate the quotient magnitude and apply the sign
	always_comb begin
		if (empty_q) begin
			crisp_next = '0;
		end else if (neg_q) begin
			crisp_next = (quo_q > NEG_LIMIT) ? X_W'(-signed'(NEG_LIMIT))
				: X_W'(-signed'(quo_q));
		end else begin
			crisp_next = (quo_q > POS_LIMIT) ? X_W'(POS_LIMIT) : X_W'(quo_q);
		end
	end

	// Sequencer, accumulators and divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			overflow_q <= 1'b0;
			area_q     <= '0;
			mom_q      <= '0;
			prev_x_q   <= '0;
			prev_m_q   <= '0;
			step_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						cur_x_q <= points.point_x;
						cur_m_q <= m_clamped;
						last_q  <= points.last_point;
						if (count_q >= CNT_MAX) begin
							// Drop the point, remember the overflow
							overflow_q <= 1'b1;
							state_q    <= points.last_point ? S_PREP : S_IDLE;
						end else if (count_q == '0) begin
							prev_x_q <= points.point_x;
							prev_m_q <= m_clamped;
							count_q  <= count_q + 1'b1;
							state_q  <= points.last_point ? S_PREP : S_IDLE;
						end else begin
							state_q <= S_THIRD;
						end
					end
				end
				S_THIRD: begin
					mid_q   <= mid_full[X_W-1:0];
					state_q <= S_AREA;
				end
				S_AREA: begin
					a2_q    <= prod[A2_W-1:0];
					area_q  <= area_q + AREA_W'($signed(prod[A2_W-1:0]));
					state_q <= S_MLO;
				end
				S_MLO: begin
					mom_q   <= mom_q + MOM_W'(prod);
					state_q <= S_MHI;
				end
				S_MHI: begin
					// Advance to the next segment
					mom_q    <= mom_q + (MOM_W'(prod) <<< A2_LO_W);
					prev_x_q <= cur_x_q;
					prev_m_q <= cur_m_q;
					count_q  <= count_q + 1'b1;
					state_q  <= last_q ? S_PREP : S_IDLE;
				end
				S_PREP: begin
					empty_q <= (area_q == '0);
					neg_q   <= mom_q[MOM_W-1] ^ area_q[AREA_W-1];
					rem_q   <= DIV_W'(mom_abs);
					dsh_q   <= DIV_W'(area_abs) << QUO_W;
					state_q <= (area_q == '0) ? S_EMIT : S_DSAT;
				end
				S_DSAT: begin
					// Quotient beyond the developed bits: force saturation
					step_q <= '0;
					dsh_q  <= dsh_q >> 1;
					if (rem_ge) begin
						quo_q   <= '1;
						state_q <= S_EMIT;
					end else begin
						quo_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (rem_ge) begin
						rem_q <= rem_q - dsh_q;
					end
					quo_q  <= {quo_q[QUO_W-2:0], rem_ge};
					dsh_q  <= dsh_q >> 1;
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					// Hand over the result and clear the set
					if (out_slot_free) begin
						count_q    <= '0;
						overflow_q <= 1'b0;
						area_q     <= '0;
						mom_q      <= '0;
						prev_x_q   <= '0;
						prev_m_q   <= '0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: load on emit, drop once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && out_slot_free) begin
			out_valid_q <= 1'b1;
		end else if (crisp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_slot_free) begin
			out_x_q     <= crisp_next;
			out_empty_q <= empty_q;
			out_over_q  <= overflow_q;
		end
	end

	assign crisp.valid           = out_valid_q;
	assign crisp.crisp_value     = out_x_q;
	assign crisp.empty_area      = out_empty_q;
	assign crisp.too_many_points = out_over_q;

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for the centroid defuzzifier: breakpoint sets in, scored centroids out.
module tb_top;
	import cdf_pkg::*;

	localparam int MAX_PTS       = DEFAULT_MAX_POINTS;
	localparam int RANDOM_POINTS = 1100;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int DRAIN_CYCLES  = 64;
	localparam int MAX_GAP       = 13;
	localparam int REPORT_LIMIT  = 10;

	typedef struct packed {
		logic signed [X_W-1:0] crisp_value;
		logic                  empty_area;
		logic                  too_many_points;
	} centroid_t;

	// One directed breakpoint; res is used only where typed is set
	typedef struct packed {
		logic signed [X_W-1:0] x;
		logic [M_W-1:0]        m;
		logic                  last;
		logic                  typed;
		centroid_t             res;
	} stim_row_t;

	typedef struct packed {
		logic      typed;
		centroid_t res;
	} point_note_t;

	localparam int DIR_ROWS = 26;
	localparam stim_row_t DIRECTED [0:DIR_ROWS-1] = '{
		// lone points straight after reset: no area
		'{16'sd0,      16'd0,     1'b1, 1'b1, '{16'sd0,   1'b1, 1'b0}},
		'{16'h7FFF,    16'd32768, 1'b1, 1'b1, '{16'sd0,   1'b1, 1'b0}},
		'{16'h8000,    16'hFFFF,  1'b1, 1'b1, '{16'sd0,   1'b1, 1'b0}},
		// singleton: equal x
		'{16'sd256,    16'd16384, 1'b0, 1'b0, '0},
		'{16'sd256,    16'd16384, 1'b1, 1'b1, '{16'sd256, 1'b0, 1'b0}},
		// rising triangle: centre at two thirds
		'{16'sd0,      16'd0,     1'b0, 1'b0, '0},
		'{16'sd768,    16'd32768, 1'b1, 1'b1, '{16'sd512, 1'b0, 1'b0}},
		// falling triangle: centre at one third
		'{16'sd0,      16'd32768, 1'b0, 1'b0, '0},
		'{16'sd768,    16'd0,     1'b1, 1'b1, '{16'sd256, 1'b0, 1'b0}},
		// rectangle
		'{16'hFE00,    16'd32768, 1'b0, 1'b0, '0},
		'{16'sd512,    16'd32768, 1'b1, 1'b0, '0},
		// trapezoid
		'{16'sd0,      16'd16384, 1'b0, 1'b0, '0},
		'{16'sd1000,   16'd32768, 1'b1, 1'b0, '0},
		// membership above one, clamped
		'{16'sd0,      16'hFFFF,  1'b0, 1'b0, '0},
		'{16'sd256,    16'd40000, 1'b1, 1'b0, '0},
		// points out of order: negative area
		'{16'sd512,    16'd32768, 1'b0, 1'b0, '0},
		'{16'hFE00,    16'd32768, 1'b1, 1'b0, '0},
		// zero membership throughout: empty area
		'{16'sd0,      16'd0,     1'b0, 1'b0, '0},
		'{16'sd100,    16'd0,     1'b0, 1'b0, '0},
		'{16'sd200,    16'd0,     1'b1, 1'b1, '{16'sd0,   1'b1, 1'b0}},
		// near-cancelling areas: quotient saturates low
		'{16'h8000,    16'd32768, 1'b0, 1'b0, '0},
		'{16'sd32766,  16'd32768, 1'b0, 1'b0, '0},
		'{16'h8001,    16'd32768, 1'b1, 1'b1, '{16'h8000,  1'b0, 1'b0}},
		// mirror image: quotient saturates high
		'{16'h7FFF,    16'd32768, 1'b0, 1'b0, '0},
		'{16'h8001,    16'd32768, 1'b0, 1'b0, '0},
		'{16'sd32766,  16'd32768, 1'b1, 1'b1, '{16'h7FFF,  1'b0, 1'b0}}
	};

	logic clk;
	logic arst_n;

	cdf_point_if  points_ch ();
	cdf_result_if crisp_ch ();

	centroid_defuzzifier_core #(.MAX_POINTS(MAX_PTS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.points (points_ch),
		.crisp  (crisp_ch)
	);

	// Predictor state for the set being gathered
	logic signed [X_W-1:0] prev_pt_x   = '0;
	logic [M_W-1:0]        prev_pt_m   = '0;
	bit                    have_pt     = 1'b0;
	longint                moment_acc  = 0;
	longint                area_acc    = 0;
	int                    kept_pts    = 0;
	bit                    dropped_pts = 1'b0;

	centroid_t   centroid_q [$];
	point_note_t note_q [$];
	int          mismatches = 0;
	bit          steady     = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Classify one segment and add its doubled area and moment
	function automatic void add_segment(int x1, int m1, int x2, int m2);
		longint dx, a2, mid;
		dx = x2 - x1;
		if (x1 == x2) begin
			a2  = 2 * m1;
			mid = x1;
		end else if (m1 == 0 || m2 == 0) begin
			a2  = dx * ((m1 > 0) ? m1 : m2);
			mid = (m1 < m2) ? x1 + (dx * 2) / 3 : x1 + dx / 3;
		end else if (m1 == m2) begin
			a2  = 2 * dx * m1;
			mid = x1 + dx / 2;
		end else begin
			a2  = dx * (m1 + m2);
			mid = x1 + dx / 2;
		end
		moment_acc += mid * a2;
		area_acc   += a2;
	endfunction

	// Fold one breakpoint into the set; on a closing point give the centroid and clear
	function automatic bit fold_point(input logic signed [X_W-1:0] x, input logic [M_W-1:0] m_raw,
		input logic last, output centroid_t res);
		int     xi, mi;
		longint quo;
		xi  = x;
		mi  = (m_raw > MEMB_ONE) ? MEMB_ONE : m_raw;
		res = '0;
		if (kept_pts >= MAX_PTS) begin
			dropped_pts = 1'b1;
		end else begin
			if (have_pt)
				add_segment(prev_pt_x, prev_pt_m, xi, mi);
			prev_pt_x = x;
			prev_pt_m = mi[M_W-1:0];
			have_pt   = 1'b1;
			kept_pts++;
		end
		if (!last)
			return 1'b0;
		res.empty_area      = (area_acc == 0);
		res.too_many_points = dropped_pts;
		if (area_acc != 0) begin
			quo = moment_acc / area_acc;
			if (quo > 32767)
				quo = 32767;
			else if (quo < -32768)
				quo = -32768;
			res.crisp_value = quo[X_W-1:0];
		end
		prev_pt_x   = '0;
		prev_pt_m   = '0;
		have_pt     = 1'b0;
		moment_acc  = 0;
		area_acc    = 0;
		kept_pts    = 0;
		dropped_pts = 1'b0;
		return 1'b1;
	endfunction

	// Predict on every accepted breakpoint, score every accepted result
	always @(posedge clk) begin
		centroid_t   pred, got;
		point_note_t note;
		if (arst_n && points_ch.valid && points_ch.ready) begin
			note = note_q.pop_front();
			if (fold_point(points_ch.point_x, points_ch.membership, points_ch.last_point, pred))
				centroid_q.push_back(note.typed ? note.res : pred);
		end
		if (arst_n && crisp_ch.valid && crisp_ch.ready) begin
			got = '{crisp_ch.crisp_value, crisp_ch.empty_area, crisp_ch.too_many_points};
			if (centroid_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("tb: centroid with none pending: value %0d empty %0b over %0b",
						got.crisp_value, got.empty_area, got.too_many_points);
			end else begin
				pred = centroid_q.pop_front();
				if (got !== pred) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("tb: centroid mismatch: value %0d/%0d empty %0b/%0b over %0b/%0b (exp/got)",
							pred.crisp_value, got.crisp_value, pred.empty_area, got.empty_area,
							pred.too_many_points, got.too_many_points);
				end
			end
		end
	end

	// Offer one breakpoint after a random gap and hold it until taken
	task automatic send_point(input logic signed [X_W-1:0] x, input logic [M_W-1:0] m,
		input logic last, input point_note_t note);
		int gap;
		gap = steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			points_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		note_q.push_back(note);
		points_ch.valid      <= 1'b1;
		points_ch.point_x    <= x;
		points_ch.membership <= m;
		points_ch.last_point <= last;
		@(posedge clk);
		while (!points_ch.ready) @(posedge clk);
	endtask

	// Drop valid and hold off until every pending centroid has come back
	task automatic hold_until_drained();
		points_ch.valid <= 1'b0;
		@(posedge clk);
		while (centroid_q.size() != 0) @(posedge clk);
	endtask

	// Mostly ordered sets with random content; some noise, some back-steps, a few long sets
	task automatic send_random_set(output int sent);
		int                    n, xi;
		bit                    noise;
		logic signed [X_W-1:0] x;
		logic [M_W-1:0]        m;
		noise = ($urandom_range(0, 9) == 0);
		n = ($urandom_range(0, 39) == 0) ? $urandom_range(MAX_PTS - 6, MAX_PTS + 14)
			: $urandom_range(1, 8);
		xi = (n > 8) ? int'($urandom_range(0, 4095)) - 32768
			: int'($urandom_range(0, 65535)) - 32768;
		m  = M_W'($urandom_range(0, MEMB_ONE));
		for (int i = 0; i < n; i++) begin
			if (noise) begin
				x = X_W'($urandom);
				m = M_W'($urandom);
			end else begin
				case ($urandom_range(0, 7))
					0: ;
					1, 2: xi += int'($urandom_range(1, 4095));
					3: xi -= int'($urandom_range(1, 1024));
					default: xi += int'($urandom_range(1, 256));
				endcase
				if (xi > 32767)
					xi = 32767;
				else if (xi < -32768)
					xi = -32768;
				x = xi[X_W-1:0];
				case ($urandom_range(0, 11))
					0, 1: m = '0;
					2, 3: m = MEMB_ONE;
					4, 5: ;
					6: m = M_W'($urandom_range(MEMB_ONE + 1, 65535));
					default: m = M_W'($urandom_range(0, MEMB_ONE));
				endcase
			end
			send_point(x, m, i == n - 1, '0);
		end
		sent = n;
	endtask

	// Result side: stall a random number of cycles before each beat
	initial begin
		int stall;
		crisp_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				crisp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			crisp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!crisp_ch.valid) @(posedge clk);
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	initial begin
		int          sent, total;
		point_note_t note;
		arst_n               <= 1'b0;
		points_ch.valid      <= 1'b0;
		points_ch.point_x    <= '0;
		points_ch.membership <= '0;
		points_ch.last_point <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (DIRECTED[i]) begin
			note.typed = DIRECTED[i].typed;
			note.res   = DIRECTED[i].res;
			send_point(DIRECTED[i].x, DIRECTED[i].m, DIRECTED[i].last, note);
		end
		hold_until_drained();

		// Sets at, just past and well past the point bound
		for (int k = 0; k < 3; k++) begin
			total = (k == 0) ? MAX_PTS : (k == 1) ? MAX_PTS + 1 : MAX_PTS + 44;
			for (int i = 0; i < total; i++)
				send_point(X_W'(-30000 + i * 200), M_W'($urandom_range(0, MEMB_ONE)),
					i == total - 1, '0);
		end

		// Random sets, with quiet stretches and the odd full drain
		total = 0;
		while (total < RANDOM_POINTS) begin
			if ($urandom_range(0, 7) == 0)
				steady = ~steady;
			if ($urandom_range(0, 14) == 0)
				hold_until_drained();
			send_random_set(sent);
			total += sent;
		end
		steady = 1'b0;

		// Drain, then allow for a closing point still in the divider
		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		mismatches += centroid_q.size();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[filelist.f]
sv/cdf_pkg.sv
sv/cdf_point_if.sv
sv/cdf_result_if.sv
sv/centroid_defuzzifier_core.sv
tb/sv/tb_top.sv
